### design/bpc_pkg.sv
package bpc_pkg;

    localparam int PORT_W     = 6;
    localparam int ANT_W      = 4;
    localparam int SYM_W      = 4;
    localparam int SC_W       = 12;
    localparam int SAMPLE_W   = 16;
    localparam int PROD_W     = 32;
    localparam int SHIFT_W    = 5;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_MASK  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROD_SHIFT = 1'd1;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd15;

    // sideband carried alongside the arithmetic
    typedef struct packed {
        logic [ANT_W-1:0] antenna;
        logic [SYM_W-1:0] symbol;
        logic [SC_W-1:0]  subcarrier;
        logic             last;
    } t_meta;

    // clamp a 32-bit value to the signed 16-bit range
    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [PROD_W-1:0] x);
        logic signed [SAMPLE_W-1:0] r;
        if (x > 32'sd32767) begin
            r = 16'sh7fff;
        end else if (x < -32'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = x[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    // 16-bit saturating add
    function automatic logic signed [SAMPLE_W-1:0] sat_add16(input logic signed [SAMPLE_W-1:0] a,
                                                              input logic signed [SAMPLE_W-1:0] b);
        logic signed [SAMPLE_W:0]   s;
        logic signed [SAMPLE_W-1:0] r;
        s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
        if (s[SAMPLE_W] != s[SAMPLE_W-1]) begin
            r = s[SAMPLE_W] ? 16'sh8000 : 16'sh7fff;
        end else begin
            r = s[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

### design/bpc_cmult.sv
// Two-stage complex multiply: products, then wrapped sum, shift and clamp.
module bpc_cmult
    import bpc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_enable,
    input  logic [SHIFT_W-1:0]         i_shift,
    input  logic signed [SAMPLE_W-1:0] i_data_re,
    input  logic signed [SAMPLE_W-1:0] i_data_im,
    input  logic signed [SAMPLE_W-1:0] i_weight_re,
    input  logic signed [SAMPLE_W-1:0] i_weight_im,
    input  t_meta                      i_meta,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [SAMPLE_W-1:0] o_re,
    output logic signed [SAMPLE_W-1:0] o_im,
    output t_meta                      o_meta
);

    logic                     r_p_valid;
    logic signed [PROD_W-1:0] r_rr, r_ii, r_ir, r_ri;
    logic                     r_p_enable;
    t_meta                    r_p_meta;

    logic                       r_c_valid;
    logic signed [SAMPLE_W-1:0] r_c_re, r_c_im;
    t_meta                      r_c_meta;

    logic                     w_c_load, w_p_load;
    logic signed [PROD_W-1:0] w_sum_re, w_sum_im;

    assign w_c_load = !r_c_valid || i_ready;
    assign w_p_load = !r_p_valid || w_c_load;
    assign o_ready  = w_p_load;

    // 32-bit wrap, as a two's-complement word
    assign w_sum_re = r_rr - r_ii;
    assign w_sum_im = r_ir + r_ri;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (w_p_load) begin
                r_p_valid <= i_valid;
            end
            if (w_c_load) begin
                r_c_valid <= r_p_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p_load && i_valid) begin
            r_rr       <= PROD_W'(i_data_re * i_weight_re);
            r_ii       <= PROD_W'(i_data_im * i_weight_im);
            r_ir       <= PROD_W'(i_data_im * i_weight_re);
            r_ri       <= PROD_W'(i_data_re * i_weight_im);
            r_p_enable <= i_enable;
            r_p_meta   <= i_meta;
        end
        if (w_c_load && r_p_valid) begin
            // masked port adds zero
            r_c_re   <= r_p_enable ? sat16(w_sum_re >>> i_shift) : '0;
            r_c_im   <= r_p_enable ? sat16(w_sum_im >>> i_shift) : '0;
            r_c_meta <= r_p_meta;
        end
    end

    assign o_valid = r_c_valid;
    assign o_re    = r_c_re;
    assign o_im    = r_c_im;
    assign o_meta  = r_c_meta;

endmodule

### design/bpc_accum.sv
// Saturating accumulator and result register.
module bpc_accum
    import bpc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [SAMPLE_W-1:0] i_re,
    input  logic signed [SAMPLE_W-1:0] i_im,
    input  t_meta                      i_meta,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [ANT_W-1:0]           o_antenna,
    output logic [SYM_W-1:0]           o_symbol,
    output logic [SC_W-1:0]            o_subcarrier,
    output logic signed [SAMPLE_W-1:0] o_re,
    output logic signed [SAMPLE_W-1:0] o_im
);

    logic signed [SAMPLE_W-1:0] r_acc_re, r_acc_im;
    logic                       r_out_valid;
    logic [ANT_W-1:0]           r_out_antenna;
    logic [SYM_W-1:0]           r_out_symbol;
    logic [SC_W-1:0]            r_out_subcarrier;
    logic signed [SAMPLE_W-1:0] r_out_re, r_out_im;

    logic                       w_out_free, w_take;
    logic signed [SAMPLE_W-1:0] w_sum_re, w_sum_im;

    // non-final items never need the result register
    assign w_out_free = !r_out_valid || i_ready;
    assign o_ready    = !i_meta.last || w_out_free;
    assign w_take     = i_valid && o_ready;

    assign w_sum_re = sat_add16(r_acc_re, i_re);
    assign w_sum_im = sat_add16(r_acc_im, i_im);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_re    <= '0;
            r_acc_im    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_acc_re <= i_meta.last ? '0 : w_sum_re;
                r_acc_im <= i_meta.last ? '0 : w_sum_im;
            end
            if (w_take && i_meta.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_meta.last) begin
            r_out_antenna    <= i_meta.antenna;
            r_out_symbol     <= i_meta.symbol;
            r_out_subcarrier <= i_meta.subcarrier;
            r_out_re         <= w_sum_re;
            r_out_im         <= w_sum_im;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_antenna    = r_out_antenna;
    assign o_symbol     = r_out_symbol;
    assign o_subcarrier = r_out_subcarrier;
    assign o_re         = r_out_re;
    assign o_im         = r_out_im;

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_meta.last) |=> (r_acc_re == '0 && r_acc_im == '0))
        else $error("accumulator not cleared after final port");

    a_result_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_meta.last) |=> r_out_valid)
        else $error("final port taken without a result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !(w_take && i_meta.last))
        else $error("pending result overwritten");

endmodule

### design/beamforming_precoder_cmac.sv
// Beamforming precoder, Q15 complex multiply-accumulate. Each transfer on the
// slave stream carries one port's sample and its beam weight for one antenna
// and subcarrier; tlast marks the final port of that subcarrier. When the
// port's bit in port_mask is set, the product (32-bit wrap) is shifted right
// arithmetically by the configured shift, clamped to 16 bits and added with
// saturation into the accumulator. The transfer carrying tlast produces one
// master transfer with the accumulated sample (this item included) and clears
// the accumulator. One item is taken every cycle unless master tready stalls it;
// the accumulator update is a single saturating add per cycle, so nothing else
// throttles the stream. Master tvalid rises once the item has passed the input,
// product and shift/clamp registers and reached the result register.
// A tlast item is held back only while the result register waits on master
// tready, which also stalls slave tready. The user must write configuration
// only while the stream is idle; the block does not enforce this. No read-back.
module beamforming_precoder_cmac
    import bpc_pkg::*;
#(
    parameter int MAX_PORTS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // slave stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // port[5:0] antenna[9:6] symbol_index[13:10] subcarrier[25:14]
    // data_re[41:26] data_im[57:42] weight_re[73:58] weight_im[89:74], rest zero
    input  logic [95:0]           i_s_axis_tdata,
    input  logic                  i_s_axis_tlast,   // last_port
    // master stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // out_antenna[3:0] out_symbol[7:4] out_subcarrier[19:8]
    // out_re[35:20] out_im[51:36], rest zero
    output logic [55:0]           o_m_axis_tdata
);

    // config registers
    logic [MAX_PORTS-1:0] r_port_mask;
    logic [SHIFT_W-1:0]   r_prod_shift;
    logic [63:0]          w_mask_full;

    // input register
    logic                       r_in_valid;
    logic [PORT_W-1:0]          r_in_port;
    logic signed [SAMPLE_W-1:0] r_in_data_re, r_in_data_im;
    logic signed [SAMPLE_W-1:0] r_in_weight_re, r_in_weight_im;
    t_meta                      r_in_meta;

    logic                       w_cm_ready, w_in_load, w_enable;
    logic                       w_cm_valid, w_acc_ready;
    logic signed [SAMPLE_W-1:0] w_cm_re, w_cm_im;
    t_meta                      w_cm_meta;

    logic [ANT_W-1:0]           w_out_antenna;
    logic [SYM_W-1:0]           w_out_symbol;
    logic [SC_W-1:0]            w_out_subcarrier;
    logic signed [SAMPLE_W-1:0] w_out_re, w_out_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_mask  <= MAX_PORTS'(1);
            r_prod_shift <= SHIFT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PORT_MASK:  r_port_mask  <= i_cfg_data[MAX_PORTS-1:0];
                CFG_PROD_SHIFT: r_prod_shift <= i_cfg_data[SHIFT_W-1:0];
                default:        ;
            endcase
        end
    end

    // ports at or above MAX_PORTS read a zero mask bit
    always_comb begin
        w_mask_full = '0;
        w_mask_full[MAX_PORTS-1:0] = r_port_mask;
    end
    assign w_enable = w_mask_full[r_in_port];

    assign w_in_load       = !r_in_valid || w_cm_ready;
    assign o_s_axis_tready = w_in_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_load) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_load && i_s_axis_tvalid) begin
            r_in_port            <= i_s_axis_tdata[5:0];
            r_in_meta.antenna    <= i_s_axis_tdata[9:6];
            r_in_meta.symbol     <= i_s_axis_tdata[13:10];
            r_in_meta.subcarrier <= i_s_axis_tdata[25:14];
            r_in_meta.last       <= i_s_axis_tlast;
            r_in_data_re         <= i_s_axis_tdata[41:26];
            r_in_data_im         <= i_s_axis_tdata[57:42];
            r_in_weight_re       <= i_s_axis_tdata[73:58];
            r_in_weight_im       <= i_s_axis_tdata[89:74];
        end
    end

    bpc_cmult u_cmult (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .o_ready     (w_cm_ready),
        .i_enable    (w_enable),
        .i_shift     (r_prod_shift),
        .i_data_re   (r_in_data_re),
        .i_data_im   (r_in_data_im),
        .i_weight_re (r_in_weight_re),
        .i_weight_im (r_in_weight_im),
        .i_meta      (r_in_meta),
        .o_valid     (w_cm_valid),
        .i_ready     (w_acc_ready),
        .o_re        (w_cm_re),
        .o_im        (w_cm_im),
        .o_meta      (w_cm_meta)
    );

    bpc_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_cm_valid),
        .o_ready      (w_acc_ready),
        .i_re         (w_cm_re),
        .i_im         (w_cm_im),
        .i_meta       (w_cm_meta),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_antenna    (w_out_antenna),
        .o_symbol     (w_out_symbol),
        .o_subcarrier (w_out_subcarrier),
        .o_re         (w_out_re),
        .o_im         (w_out_im)
    );

    assign o_m_axis_tdata = {4'd0, w_out_im, w_out_re, w_out_subcarrier,
                             w_out_symbol, w_out_antenna};

endmodule
